// ----- rtl/tcphf_pkg.sv -----
// ----------------------------------------------------------------------------
// tcphf_pkg
// Shared types and constants for the TCP header rewrite and checksum block.
// ----------------------------------------------------------------------------
package tcphf_pkg;

    // Longest packet in bytes that still counts as good
    localparam int unsigned MAX_LEN = 65535;

    // Fixed header geometry
    localparam int unsigned MIN_HDR_BYTES = 20;
    localparam int unsigned HTTP_PORT     = 80;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_PORT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAND_PORT_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAGS_EN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAGS_VALUE  = 2'd3;

    // Port pattern phases
    localparam logic [2:0] PHASE_RAND_PORT = 3'd3;
    localparam logic [2:0] PHASE_HTTP_LIM  = 3'd2;

    // Serial remainder unit: one quotient bit per cycle
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Controller to datapath commands
    typedef struct packed {
        logic take;      // accept one packet byte
        logic check;     // length checks, load remainder unit
        logic div_step;  // one remainder iteration
        logic apply;     // rewrite offset, flags and port
        logic sum;       // add pseudo header and rewritten words
        logic fold;      // fold carries into low 16 bits
        logic load_out;  // move result to output register, clear packet
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;  // output register holds a beat not taken this cycle
    } t_status;

endpackage

// ----- rtl/tcphf_in_if.sv -----
// ----------------------------------------------------------------------------
// tcphf_in_if
// Byte input channel: valid/ready with packet byte and per-packet randoms.
// ----------------------------------------------------------------------------
interface tcphf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [15:0] rand_offset;
    logic [9:0] rand_port;

    modport source (output valid, output data_byte, output last_byte,
                    output rand_offset, output rand_port, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input rand_offset, input rand_port, output ready);
endinterface

// ----- rtl/tcphf_out_if.sv -----
// ----------------------------------------------------------------------------
// tcphf_out_if
// Result channel: valid/ready with checksum and rewritten header fields.
// ----------------------------------------------------------------------------
interface tcphf_out_if;
    logic        valid;
    logic        ready;
    logic        packet_ok;
    logic [15:0] tcp_checksum;
    logic [3:0]  data_offset_words;
    logic [7:0]  tcp_flags;
    logic [15:0] dest_port;

    modport source (output valid, output packet_ok, output tcp_checksum,
                    output data_offset_words, output tcp_flags, output dest_port,
                    input ready);
    modport sink   (input valid, input packet_ok, input tcp_checksum,
                    input data_offset_words, input tcp_flags, input dest_port,
                    output ready);
endinterface

// ----- rtl/tcphf_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcphf_ctrl
// Sequencer: byte receive, end-of-packet checks, serial remainder, fold, emit.
// ----------------------------------------------------------------------------
module tcphf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  tcphf_pkg::t_status i_status,
    output logic              o_in_ready,
    output tcphf_pkg::t_cmd   o_cmd
);

    typedef enum logic [7:0] {
        S_RX    = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_APPLY = 8'b0000_1000,
        S_SUM   = 8'b0001_0000,
        S_FOLD1 = 8'b0010_0000,
        S_FOLD2 = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                           r_state, n_state;
    logic [tcphf_pkg::DIV_CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_RX: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt       = '0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == tcphf_pkg::DIV_CNT_W'(tcphf_pkg::DIV_STEPS - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FOLD1;
            end
            S_FOLD1: begin
                o_cmd.fold = 1'b1;
                n_state    = S_FOLD2;
            end
            S_FOLD2: begin
                o_cmd.fold = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold until the output register frees up
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_RX;
                end
            end
            default: begin
                n_state = S_RX;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_RX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- rtl/tcphf_dp.sv -----
// ----------------------------------------------------------------------------
// tcphf_dp
// Datapath: header capture, checksum accumulator, remainder unit, output reg.
// ----------------------------------------------------------------------------
module tcphf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcphf_pkg::t_cmd                     i_cmd,
    output tcphf_pkg::t_status                  o_status,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [tcphf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcphf_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input payload
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    input  logic [15:0]                         i_rand_offset,
    input  logic [9:0]                          i_rand_port,
    // result
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_packet_ok,
    output logic [15:0]                         o_tcp_checksum,
    output logic [3:0]                          o_data_offset_words,
    output logic [7:0]                          o_tcp_flags,
    output logic [15:0]                         o_dest_port
);

    // configuration registers
    logic [15:0] r_fixed_port;
    logic        r_rand_port_en;
    logic        r_flags_en;
    logic [7:0]  r_flags_value;

    // per-packet state
    logic [15:0] r_byte_index;
    logic [5:0]  r_hdr_bytes;
    logic [15:0] r_total_len;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_held_offset;
    logic [9:0]  r_held_port;
    logic [3:0]  r_new_offset, n_new_offset;
    logic [7:0]  r_new_flags, n_new_flags;
    logic [15:0] r_new_port, n_new_port;
    logic [3:0]  r_reserved, n_reserved;
    logic [2:0]  r_phase;

    // end-of-packet results
    logic        r_ok;
    logic        r_bad_off;
    logic [15:0] r_tlen;
    logic [15:0] r_divisor;
    logic [15:0] r_dividend;
    logic [15:0] r_rem;

    // output register
    logic        r_out_valid;
    logic        r_out_ok;
    logic [15:0] r_out_csum;
    logic [3:0]  r_out_off;
    logic [7:0]  r_out_flags;
    logic [15:0] r_out_port;

    // byte capture decode
    logic [15:0] w_h16;
    logic        w_in_tcp;
    logic [31:0] w_byte_word;

    // checks
    logic [16:0] w_plen;
    logic [16:0] w_h17;
    logic [16:0] w_ilen17;
    logic        w_ok;
    logic [15:0] w_tlen;
    logic [5:0]  w_off_bytes;

    // remainder step
    logic [16:0] w_trial;
    logic [16:0] w_diff;

    // rewrite and sum
    logic [15:0] w_noff;
    logic [15:0] w_hdr_word;
    logic [17:0] w_add;
    logic [16:0] w_fold;

    assign w_h16       = {10'd0, r_hdr_bytes};
    assign w_in_tcp    = (r_byte_index >= 16'd4) && (r_byte_index < r_total_len)
                         && (r_byte_index > 16'd8) && (r_byte_index != 16'd10)
                         && (r_byte_index != 16'd11);
    assign w_byte_word = r_byte_index[0] ? {24'd0, i_data_byte} : {16'd0, i_data_byte, 8'd0};

    assign w_plen      = {1'b0, r_byte_index} + 17'd1;
    assign w_h17       = {11'd0, r_hdr_bytes};
    assign w_ilen17    = {1'b0, r_total_len};
    assign w_ok        = !(w_plen > 17'(tcphf_pkg::MAX_LEN))
                         && !(w_plen < 17'(tcphf_pkg::MIN_HDR_BYTES))
                         && !(w_h17 < 17'(tcphf_pkg::MIN_HDR_BYTES))
                         && !(w_h17 > w_plen)
                         && !(w_ilen17 > w_plen)
                         && !(w_ilen17 < w_h17 + 17'(tcphf_pkg::MIN_HDR_BYTES));
    assign w_tlen      = r_total_len - w_h16;
    assign w_off_bytes = {r_new_offset, 2'b00};

    assign w_trial     = {r_rem, r_dividend[15]};
    assign w_diff      = w_trial - {1'b0, r_divisor};

    assign w_noff      = (r_divisor != 16'd0) ? r_rem : r_tlen;
    assign w_hdr_word  = {r_new_offset, r_reserved, r_new_flags};
    assign w_add       = {2'b00, r_tlen} + {2'b00, w_hdr_word} + {2'b00, r_new_port};
    assign w_fold      = {1'b0, r_acc[31:16]} + {1'b0, r_acc[15:0]};

    // byte capture and rewrite of the tracked header fields
    always_comb begin
        n_acc        = r_acc;
        n_new_offset = r_new_offset;
        n_new_flags  = r_new_flags;
        n_new_port   = r_new_port;
        n_reserved   = r_reserved;
        if (i_cmd.take && w_in_tcp) begin
            if (r_byte_index == w_h16 + 16'd2) begin
                n_new_port[15:8] = i_data_byte;
            end else if (r_byte_index == w_h16 + 16'd3) begin
                n_new_port[7:0] = i_data_byte;
            end else if (r_byte_index == w_h16 + 16'd12) begin
                n_new_offset = i_data_byte[7:4];
                n_reserved   = i_data_byte[3:0];
            end else if (r_byte_index == w_h16 + 16'd13) begin
                n_new_flags = i_data_byte;
            end else if ((r_byte_index != w_h16 + 16'd16)
                         && (r_byte_index != w_h16 + 16'd17)) begin
                n_acc = r_acc + w_byte_word;
            end
        end
        if (i_cmd.apply && r_ok) begin
            if (r_bad_off) begin
                n_new_offset = w_noff[5:2];
            end
            if (r_flags_en) begin
                n_new_flags = r_flags_value;
            end
            if (r_fixed_port != 16'd0) begin
                n_new_port = r_fixed_port;
            end else if (r_rand_port_en) begin
                if (r_phase < tcphf_pkg::PHASE_HTTP_LIM) begin
                    n_new_port = 16'(tcphf_pkg::HTTP_PORT);
                end else if (r_phase == tcphf_pkg::PHASE_RAND_PORT) begin
                    n_new_port = {6'd0, r_held_port};
                end
            end
        end
        if (i_cmd.sum) begin
            n_acc = r_acc + {14'd0, w_add};
        end
        if (i_cmd.fold) begin
            n_acc = {15'd0, w_fold};
        end
        // clear the packet state once the result is loaded
        if (i_cmd.load_out) begin
            n_acc        = '0;
            n_new_offset = '0;
            n_new_flags  = '0;
            n_new_port   = '0;
            n_reserved   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_port   <= '0;
            r_rand_port_en <= 1'b0;
            r_flags_en     <= 1'b0;
            r_flags_value  <= '0;
            r_byte_index   <= '0;
            r_hdr_bytes    <= '0;
            r_total_len    <= '0;
            r_acc          <= '0;
            r_held_offset  <= '0;
            r_held_port    <= '0;
            r_new_offset   <= '0;
            r_new_flags    <= '0;
            r_new_port     <= '0;
            r_reserved     <= '0;
            r_phase        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    tcphf_pkg::CFG_FIXED_PORT:   r_fixed_port   <= i_cfg_wdata;
                    tcphf_pkg::CFG_RAND_PORT_EN: r_rand_port_en <= i_cfg_wdata[0];
                    tcphf_pkg::CFG_FLAGS_EN:     r_flags_en     <= i_cfg_wdata[0];
                    tcphf_pkg::CFG_FLAGS_VALUE:  r_flags_value  <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end

            r_acc        <= n_acc;
            r_new_offset <= n_new_offset;
            r_new_flags  <= n_new_flags;
            r_new_port   <= n_new_port;
            r_reserved   <= n_reserved;

            if (i_cmd.take) begin
                if (r_byte_index == 16'd0) begin
                    r_held_offset <= i_rand_offset;
                    r_held_port   <= i_rand_port;
                    r_hdr_bytes   <= {i_data_byte[3:0], 2'b00};
                end
                if (r_byte_index == 16'd2) begin
                    r_total_len[15:8] <= i_data_byte;
                end
                if (r_byte_index == 16'd3) begin
                    r_total_len[7:0] <= i_data_byte;
                end
                // last byte keeps its index for the length check; saturate
                if ((r_byte_index != 16'hFFFF) && !i_last_byte) begin
                    r_byte_index <= r_byte_index + 16'd1;
                end
            end

            if (i_cmd.apply && r_ok) begin
                r_phase <= r_phase + 3'd1;
            end

            if (i_cmd.load_out) begin
                r_out_valid  <= 1'b1;
                r_byte_index <= '0;
                r_hdr_bytes  <= '0;
                r_total_len  <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // end-of-packet evaluation and serial remainder (no reset: payload)
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_ok       <= w_ok;
            r_tlen     <= w_tlen;
            r_bad_off  <= (w_off_bytes < 6'(tcphf_pkg::MIN_HDR_BYTES))
                          || ({10'd0, w_off_bytes} > w_tlen);
            r_divisor  <= w_tlen - 16'(tcphf_pkg::MIN_HDR_BYTES);
            r_dividend <= r_held_offset;
            r_rem      <= '0;
        end
        if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[14:0], 1'b0};
            r_rem      <= w_diff[16] ? w_trial[15:0] : w_diff[15:0];
        end
        if (i_cmd.load_out) begin
            r_out_ok    <= r_ok;
            r_out_csum  <= r_ok ? ~r_acc[15:0] : 16'd0;
            r_out_off   <= r_ok ? r_new_offset : 4'd0;
            r_out_flags <= r_ok ? r_new_flags : 8'd0;
            r_out_port  <= r_ok ? r_new_port : 16'd0;
        end
    end

    assign o_status.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_packet_ok         = r_out_ok;
    assign o_tcp_checksum      = r_out_csum;
    assign o_data_offset_words = r_out_off;
    assign o_tcp_flags         = r_out_flags;
    assign o_dest_port         = r_out_port;

endmodule

// ----- rtl/tcp_header_force_and_checksum.sv -----
// ----------------------------------------------------------------------------
// tcp_header_force_and_checksum
// IPv4/TCP length check, header field rewrite and TCP checksum, byte stream in.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one packet byte per beat, starting at the first IP header
//   byte, with last_byte set on the final beat. rand_offset and rand_port are
//   sampled on the first beat of each packet.
//   o_out carries exactly one beat per packet: packet_ok, the TCP checksum and
//   the rewritten data offset, flags and destination port. Downstream patches
//   the packet from these; a beat with packet_ok low means drop the packet.
//   The cfg port writes fixed_port (0), random_port_enable (1),
//   flags_force_enable (2) and flags_value (3); write only while idle.
// Timing:
//   After the last byte the block keeps i_in.ready low for the length
//   checks, the 16-step bit-serial remainder of the random offset, then
//   rewrite, sum, two carry folds and the output load, which waits while
//   the output register is still busy. The result shows on o_out in the
//   cycle after the output load.
// Reset and stall:
//   Synchronous active-low reset clears config, packet state and the port
//   pattern phase. The result waits in an output register, so a stalled
//   receiver only holds the block once a second result is ready to load.
// ----------------------------------------------------------------------------
module tcp_header_force_and_checksum (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tcphf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcphf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    tcphf_in_if.sink                         i_in,
    tcphf_out_if.source                      o_out
);

    tcphf_pkg::t_cmd    w_cmd;
    tcphf_pkg::t_status w_status;
    logic               w_in_ready;

    // sequencer: owns the handshake on the byte side
    tcphf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_byte),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    // datapath: capture, accumulate, divide, fold and hold the result beat
    tcphf_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_data_byte         (i_in.data_byte),
        .i_last_byte         (i_in.last_byte),
        .i_rand_offset       (i_in.rand_offset),
        .i_rand_port         (i_in.rand_port),
        .o_out_valid         (o_out.valid),
        .i_out_ready         (o_out.ready),
        .o_packet_ok         (o_out.packet_ok),
        .o_tcp_checksum      (o_out.tcp_checksum),
        .o_data_offset_words (o_out.data_offset_words),
        .o_tcp_flags         (o_out.tcp_flags),
        .o_dest_port         (o_out.dest_port)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream testbench for tcp_header_force_and_checksum: it predicts each
// per-packet rewrite result (length verdict, data offset, flags, port and
// TCP checksum) from the accepted bytes, and compares it with every result
// beat. Stimulus is a directed set of edge packets followed by random
// good and broken packets under several register settings, with bursty
// input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;

    // Give the block time for its post-packet sequence and output load, with margin
    localparam int DRAIN_CYCLES = 40;
    // Receiver hold-off long enough to span several short packets
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] roff;
        logic [9:0]  rport;
    } t_pkt_byte;

    typedef struct packed {
        logic        ok;
        logic [15:0] csum;
        logic [3:0]  doff;
        logic [7:0]  flags;
        logic [15:0] port;
    } t_rewrite;

    logic clk = 1'b0;
    logic rst_n;
    logic                             cfg_wr_en;
    logic [tcphf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tcphf_pkg::CFG_DATA_W-1:0] cfg_wdata;

    tcphf_in_if  in_ch ();
    tcphf_out_if out_ch ();

    tcp_header_force_and_checksum u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus and expectation stores
    // ------------------------------------------------------------------------
    t_pkt_byte pending_bytes[$];   // bytes waiting to be offered
    t_rewrite  exp_rewrites[$];    // predicted result beats, oldest first
    int        mismatch_count = 0;
    int        results_seen   = 0;
    logic      byte_taken     = 1'b0;
    bit        hold_due       = 1'b0;
    bit        no_idle        = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor state: register copies and per-packet tracking
    // ------------------------------------------------------------------------
    logic [15:0] reg_fixed_port = '0;
    logic        reg_rand_en    = 1'b0;
    logic        reg_flags_en   = 1'b0;
    logic [7:0]  reg_flags_val  = '0;

    logic [15:0] pos        = '0;   // byte position in the packet, saturating
    logic [5:0]  hdr_bytes  = '0;   // IP header length in bytes
    logic [15:0] tot_len    = '0;   // IP total length field
    logic [31:0] sum_acc    = '0;   // running sum of the covered 16-bit words
    logic [2:0]  pkt_phase  = '0;   // port pattern position, good packets only
    logic [15:0] held_roff  = '0;
    logic [9:0]  held_rport = '0;
    logic [3:0]  off_acc    = '0;
    logic [7:0]  flags_acc  = '0;
    logic [15:0] port_acc   = '0;
    logic [3:0]  rsv_nib    = '0;

    // Fold one accepted byte into the packet state; at the last byte,
    // decide the verdict, apply the rewrites and queue the expected beat.
    function automatic void predict_byte(input t_pkt_byte bt);
        int unsigned i, h, plen, tlen, r, noff, acc;
        bit          skip;
        t_rewrite    res;
        i = pos;
        h = hdr_bytes;
        if (i == 0) begin
            held_roff  = bt.roff;
            held_rport = bt.rport;
            hdr_bytes  = {bt.data[3:0], 2'b00};
        end
        if (i == 2) tot_len[15:8] = bt.data;
        if (i == 3) tot_len[7:0]  = bt.data;

        // Skip the zeroed IP words, the checksum word and bytes past total length;
        // capture the rewritable TCP fields instead of summing them.
        skip = (i < 4) || (i >= tot_len) || (i <= 8) || (i == 10) || (i == 11);
        if (!skip) begin
            if (i == h + 2) begin
                port_acc[15:8] = bt.data;
            end else if (i == h + 3) begin
                port_acc[7:0] = bt.data;
            end else if (i == h + 12) begin
                off_acc = bt.data[7:4];
                rsv_nib = bt.data[3:0];
            end else if (i == h + 13) begin
                flags_acc = bt.data;
            end else if (i != h + 16 && i != h + 17) begin
                sum_acc = sum_acc + ((i % 2 == 1) ? 32'(bt.data) : (32'(bt.data) << 8));
            end
        end

        if (!bt.last) begin
            if (pos != 16'hFFFF) pos = pos + 16'd1;
            return;
        end

        plen = pos + 1;
        h    = hdr_bytes;
        res  = '0;
        if (plen > tcphf_pkg::MAX_LEN || plen < tcphf_pkg::MIN_HDR_BYTES) begin
            res.ok = 1'b0;
        end else if (h < tcphf_pkg::MIN_HDR_BYTES || h > plen) begin
            res.ok = 1'b0;
        end else if (tot_len > plen || tot_len < h + tcphf_pkg::MIN_HDR_BYTES) begin
            res.ok = 1'b0;
        end else begin
            res.ok = 1'b1;
        end

        if (res.ok) begin
            tlen = tot_len - h;
            // Repair a data offset that is too short or runs past the segment
            if ({off_acc, 2'b00} < tcphf_pkg::MIN_HDR_BYTES || {off_acc, 2'b00} > tlen) begin
                r    = tlen - tcphf_pkg::MIN_HDR_BYTES;
                noff = (r > 0) ? (held_roff % r) : tlen;
                off_acc = noff[5:2];
            end
            if (reg_flags_en) flags_acc = reg_flags_val;
            if (reg_fixed_port != 16'd0) begin
                port_acc = reg_fixed_port;
            end else if (reg_rand_en) begin
                if (pkt_phase < tcphf_pkg::PHASE_HTTP_LIM) begin
                    port_acc = 16'(tcphf_pkg::HTTP_PORT);
                end else if (pkt_phase == tcphf_pkg::PHASE_RAND_PORT) begin
                    port_acc = {6'd0, held_rport};
                end
            end
            pkt_phase = pkt_phase + 3'd1;

            acc = sum_acc + tlen + {off_acc, rsv_nib, flags_acc} + port_acc;
            while (acc >> 16) acc = (acc & 32'hFFFF) + (acc >> 16);
            res.csum  = ~acc[15:0];
            res.doff  = off_acc;
            res.flags = flags_acc;
            res.port  = port_acc;
        end
        exp_rewrites.push_back(res);

        pos       = '0;
        hdr_bytes = '0;
        tot_len   = '0;
        sum_acc   = '0;
        off_acc   = '0;
        flags_acc = '0;
        port_acc  = '0;
        rsv_nib   = '0;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sample both channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_rewrite want;
        if (!rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                // Predict from what was really on the bus, then retire it
                predict_byte('{in_ch.data_byte, in_ch.last_byte,
                               in_ch.rand_offset, in_ch.rand_port});
                void'(pending_bytes.pop_front());
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (results_seen % 12 == 3) hold_due <= 1'b1;
                if (exp_rewrites.size() == 0) begin
                    $error("result beat with no packet outstanding");
                    mismatch_count++;
                end else begin
                    want = exp_rewrites.pop_front();
                    check_field("packet_ok", want.ok, out_ch.packet_ok);
                    check_field("tcp_checksum", want.csum, out_ch.tcp_checksum);
                    check_field("data_offset_words", want.doff, out_ch.data_offset_words);
                    check_field("tcp_flags", want.flags, out_ch.tcp_flags);
                    check_field("dest_port", want.port, out_ch.dest_port);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !byte_taken) begin
            // hold the offered beat until it is taken
        end else if ((gap_left > 0 && !no_idle) || pending_bytes.size() == 0) begin
            in_ch.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
        end else begin
            in_ch.valid       <= 1'b1;
            in_ch.data_byte   <= pending_bytes[0].data;
            in_ch.last_byte   <= pending_bytes[0].last;
            in_ch.rand_offset <= pending_bytes[0].roff;
            in_ch.rand_port   <= pending_bytes[0].rport;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 64);
                gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: short random stalls, plus an occasional long hold-off
    // that backs the block up until it stalls its byte input
    // ------------------------------------------------------------------------
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;
    int unsigned run_left   = 0;

    always @(negedge clk) begin
        logic rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (hold_due) begin
            hold_due  = 1'b0;
            hold_left = LONG_HOLD - 1;
            rdy = 1'b0;
        end else if (stall_left > 0 && !no_idle) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if (run_left > 0) begin
                run_left--;
            end else begin
                run_left   = $urandom_range(0, 30);
                stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
            end
        end
        out_ch.ready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Helpers for the sequence below
    // ------------------------------------------------------------------------

    // Queue one packet: plen bytes of fill (negative fill means random), with
    // the IHL nibble, total length and TCP data offset nibble laid in.
    task automatic queue_packet(input int unsigned plen, input logic [3:0] ihl,
                                input logic [15:0] tot, input logic [3:0] doff,
                                input int fill);
        t_pkt_byte beat;
        int unsigned h;
        h = ihl * 4;
        for (int unsigned i = 0; i < plen; i++) begin
            beat.data = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == 0) beat.data[3:0] = ihl;
            if (i == 2) beat.data = tot[15:8];
            if (i == 3) beat.data = tot[7:0];
            if (i == h + 12) beat.data[7:4] = doff;
            beat.last  = (i == plen - 1);
            beat.roff  = 16'($urandom);
            beat.rport = 10'($urandom_range(0, 1023));
            pending_bytes.push_back(beat);
        end
    endtask

    // Drive one register write; mirror it in the predictor
    task automatic write_reg(input logic [tcphf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcphf_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            tcphf_pkg::CFG_FIXED_PORT:   reg_fixed_port = val;
            tcphf_pkg::CFG_RAND_PORT_EN: reg_rand_en    = val[0];
            tcphf_pkg::CFG_FLAGS_EN:     reg_flags_en   = val[0];
            tcphf_pkg::CFG_FLAGS_VALUE:  reg_flags_val  = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Wait for every byte to go in and every result to come out, then let
    // the block settle before anything else changes
    task automatic drain_block();
        do @(negedge clk);
        while (pending_bytes.size() != 0 || exp_rewrites.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_bytes, phase_pkts, kind, h, tlen, plen, dmax;
        logic [3:0]  ihl, doff;
        logic [15:0] tot;

        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = tcphf_pkg::CFG_FIXED_PORT;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.last_byte   = 1'b0;
        in_ch.rand_offset = '0;
        in_ch.rand_port   = '0;
        out_ch.ready      = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed edge packets under reset register values
        queue_packet(40, 4'd5, 16'd40, 4'd5, -1);     // smallest good packet
        queue_packet(40, 4'd5, 16'd40, 4'd0, -1);     // bad offset, no room to draw from
        queue_packet(60, 4'd5, 16'd60, 4'd1, -1);     // bad offset, drawn by remainder
        queue_packet(44, 4'd5, 16'd44, 4'd15, -1);    // offset past the segment end
        queue_packet(81, 4'd15, 16'd81, 4'd5, -1);    // longest header, odd length
        queue_packet(56, 4'd5, 16'd50, 4'd6, -1);     // trailing bytes past total length
        queue_packet(100, 4'd15, 16'd100, 4'd15, 255); // all-ones bytes
        queue_packet(40, 4'd5, 16'd40, 4'd0, 0);      // all-zero bytes
        queue_packet(1, 4'd5, 16'd40, 4'd5, -1);      // single-byte packet
        queue_packet(19, 4'd5, 16'd19, 4'd5, -1);     // one byte short of a header
        queue_packet(40, 4'd4, 16'd40, 4'd5, -1);     // header length below minimum
        queue_packet(40, 4'd15, 16'd40, 4'd5, -1);    // header longer than the packet
        queue_packet(40, 4'd5, 16'd41, 4'd5, -1);     // total length beyond received
        queue_packet(40, 4'd5, 16'd39, 4'd5, -1);     // total too short for TCP
        queue_packet(40, 4'd5, 16'hFFFF, 4'd5, -1);   // maximal total length field
        queue_packet(40, 4'd5, 16'd40, 4'd5, -1);     // good packet after the broken ones
        drain_block();

        // Random traffic across several register settings
        for (int p = 1; p <= 6; p++) begin
            case (p)
                1: begin
                    write_reg(tcphf_pkg::CFG_FIXED_PORT, 16'd0);
                    write_reg(tcphf_pkg::CFG_RAND_PORT_EN, 16'd1);
                    write_reg(tcphf_pkg::CFG_FLAGS_EN, 16'd1);
                    write_reg(tcphf_pkg::CFG_FLAGS_VALUE, 16'h00FF);
                end
                2: begin
                    write_reg(tcphf_pkg::CFG_FIXED_PORT, 16'hFFFF);
                    write_reg(tcphf_pkg::CFG_RAND_PORT_EN, 16'd0);
                    write_reg(tcphf_pkg::CFG_FLAGS_EN, 16'd0);
                    write_reg(tcphf_pkg::CFG_FLAGS_VALUE, 16'h0000);
                end
                3: begin
                    write_reg(tcphf_pkg::CFG_FIXED_PORT, 16'd0);
                    write_reg(tcphf_pkg::CFG_RAND_PORT_EN, 16'd1);
                    write_reg(tcphf_pkg::CFG_FLAGS_EN, 16'd0);
                    write_reg(tcphf_pkg::CFG_FLAGS_VALUE, 16'($urandom_range(0, 255)));
                end
                4: begin
                    write_reg(tcphf_pkg::CFG_FIXED_PORT, 16'd1);
                    write_reg(tcphf_pkg::CFG_RAND_PORT_EN, 16'd1);
                    write_reg(tcphf_pkg::CFG_FLAGS_EN, 16'd1);
                    write_reg(tcphf_pkg::CFG_FLAGS_VALUE, 16'h0000);
                end
                default: begin
                    write_reg(tcphf_pkg::CFG_FIXED_PORT,
                              ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom));
                    write_reg(tcphf_pkg::CFG_RAND_PORT_EN, 16'($urandom_range(0, 1)));
                    write_reg(tcphf_pkg::CFG_FLAGS_EN, 16'($urandom_range(0, 1)));
                    write_reg(tcphf_pkg::CFG_FLAGS_VALUE, 16'($urandom_range(0, 255)));
                end
            endcase
            // Run one setting back to back on both sides
            no_idle = (p == 3);

            phase_bytes = 0;
            phase_pkts  = 0;
            while (phase_bytes < 70 || phase_pkts < 2) begin
                kind = $urandom_range(0, 9);
                doff = 4'($urandom);
                if (kind <= 6) begin
                    // well-formed lengths, offset mostly sane
                    ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15))
                                                       : 4'($urandom_range(5, 7));
                    h    = ihl * 4;
                    tlen = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(20, 90);
                    tot  = 16'(h + tlen);
                    plen = tot + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
                    dmax = (tlen / 4 > 15) ? 15 : tlen / 4;
                    if ($urandom_range(0, 2) != 0) doff = 4'($urandom_range(5, dmax));
                end else if (kind == 7) begin
                    // too short for any header
                    plen = $urandom_range(1, 19);
                    ihl  = 4'($urandom);
                    tot  = 16'($urandom);
                end else if (kind == 8) begin
                    // header length wrong
                    if ($urandom_range(0, 1) == 0) begin
                        ihl  = 4'($urandom_range(0, 4));
                        plen = $urandom_range(20, 60);
                    end else begin
                        ihl  = 4'($urandom_range(6, 15));
                        plen = $urandom_range(20, ihl * 4 - 1);
                    end
                    tot = 16'($urandom_range(0, plen));
                end else begin
                    // total length disagrees with what arrives
                    ihl  = 4'($urandom_range(5, 15));
                    h    = ihl * 4;
                    plen = $urandom_range(h + 20, h + 40);
                    tot  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(plen + 1, 16'hFFFF))
                                                       : 16'($urandom_range(0, h + 19));
                end
                queue_packet(plen, ihl, tot, doff, -1);
                phase_bytes += plen;
                phase_pkts++;
            end
            drain_block();
        end

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
